// ===== sv/skc_pkg.sv =====
package skc_pkg;

	localparam int PAIR_W    = 64;
	localparam int WORD_W    = 32;
	localparam int MAX_PAIRS = 5;
	localparam int HELD_W    = 6;
	localparam int SW_W      = 16;
	localparam int TAG_W     = 8;
	localparam int FRAG_IN_W = 16;

	localparam logic [SW_W-1:0] BASE_RESET = 16'd8001;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_DUP        = 2'd1,
		ST_BAD_SWITCH = 2'd2,
		ST_BAD_FRAG   = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic                epoch_started;
		logic                complete;
		logic [HELD_W-1:0]   held;
		logic                wr;
		logic                rd_hit;
	} res_t;

endpackage

// ===== sv/sketch_fragment_collector.sv =====
// Sketch fragment collector.
// Command channel: an item is taken on a rising edge with start high and
// busy low. busy stays low, so a beat may be issued on every cycle.
// op selects store or read back; the switch slot is source_switch minus base_switch_id, which the user
// must write through cfg_we/cfg_data while no beat is in flight; the block does not enforce this.
// Result channel: done rises at the edge after the one that took the beat and
// stays high for exactly one cycle; the receiver cannot stall it. One
// result per cycle, in order.
// Stage one registers the command, checks slot and fragment range, looks up
// and updates the per-switch epoch, count and presence flops, and issues the
// write or read of the fragment RAM. Stage two holds the result and the
// registered RAM read data.
// A beat may follow a store to the same fragment in the next cycle: state is
// updated at the end of stage one, before the next beat looks at it.
// Reset clears all presence marks, counts and epochs and loads the base id
// with 8001; the fragment RAM is not cleared and is read only where marked.
module sketch_fragment_collector #(
	parameter int NUM_SWITCHES = 6,
	parameter int NUM_ARRAYS   = 3,
	parameter int NUM_BUCKETS  = 16,
	parameter int DELAY_WORDS  = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [15:0]                           cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  op,
	input  logic [15:0]                           source_switch,
	input  logic [7:0]                            epoch_tag,
	input  logic [15:0]                           fragment_index,
	input  logic [63:0]                           delay_pair_0,
	input  logic [63:0]                           delay_pair_1,
	input  logic [63:0]                           delay_pair_2,
	input  logic [63:0]                           delay_pair_3,
	input  logic [63:0]                           delay_pair_4,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic                                  epoch_started,
	output logic                                  sketch_complete,
	output logic [5:0]                            fragments_held,
	output logic [63:0]                           read_pair_0,
	output logic [63:0]                           read_pair_1,
	output logic [63:0]                           read_pair_2,
	output logic [63:0]                           read_pair_3,
	output logic [63:0]                           read_pair_4
);

	localparam int FRAGS  = NUM_ARRAYS * NUM_BUCKETS;
	localparam int PAIRS  = (DELAY_WORDS + 1) / 2;
	localparam int DEPTH  = NUM_SWITCHES * FRAGS;
	localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int MEM_W  = PAIRS * skc_pkg::PAIR_W;

	logic [skc_pkg::SW_W-1:0] base_q;

	logic                              valid_s1;
	logic                              op_s1;
	logic [skc_pkg::SW_W-1:0]          src_s1;
	logic [skc_pkg::TAG_W-1:0]         tag_s1;
	logic [skc_pkg::FRAG_IN_W-1:0]     frag_s1;
	logic [skc_pkg::PAIR_W-1:0]        pair_s1 [skc_pkg::MAX_PAIRS];

	skc_pkg::res_t                     res;
	logic [ADDR_W-1:0]                 addr;
	logic [MEM_W-1:0]                  wdata;
	logic [MEM_W-1:0]                  rdata;

	logic                              done_s2;
	skc_pkg::res_t                     res_s2;
	logic [skc_pkg::PAIR_W-1:0]        rp [skc_pkg::MAX_PAIRS];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= skc_pkg::BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1      <= op;
			src_s1     <= source_switch;
			tag_s1     <= epoch_tag;
			frag_s1    <= fragment_index;
			pair_s1[0] <= delay_pair_0;
			pair_s1[1] <= delay_pair_1;
			pair_s1[2] <= delay_pair_2;
			pair_s1[3] <= delay_pair_3;
			pair_s1[4] <= delay_pair_4;
		end
		res_s2 <= res;
	end

	skc_state #(
		.NUM_SWITCHES (NUM_SWITCHES),
		.NUM_ARRAYS   (NUM_ARRAYS),
		.NUM_BUCKETS  (NUM_BUCKETS)
	) u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid          (valid_s1),
		.op             (op_s1),
		.source_switch  (src_s1),
		.epoch_tag      (tag_s1),
		.fragment_index (frag_s1),
		.base_switch_id (base_q),
		.res            (res),
		.addr           (addr)
	);

	for (genvar k = 0; k < PAIRS; k++) begin : g_wr
		assign wdata[k*skc_pkg::PAIR_W +: skc_pkg::PAIR_W] = pair_s1[k];
	end

	skc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (valid_s1 && res.wr),
		.waddr (addr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	// unused delay words read back as zero
	for (genvar k = 0; k < skc_pkg::MAX_PAIRS; k++) begin : g_rd
		if (k < PAIRS) begin : g_on
			logic [skc_pkg::WORD_W-1:0] lo;
			logic [skc_pkg::WORD_W-1:0] hi;
			assign lo = (2 * k < DELAY_WORDS) ?
				rdata[k*skc_pkg::PAIR_W +: skc_pkg::WORD_W] : '0;
			assign hi = (2 * k + 1 < DELAY_WORDS) ?
				rdata[k*skc_pkg::PAIR_W + skc_pkg::WORD_W +: skc_pkg::WORD_W] : '0;
			assign rp[k] = res_s2.rd_hit ? {hi, lo} : '0;
		end else begin : g_off
			assign rp[k] = '0;
		end
	end

	assign done            = done_s2;
	assign status          = res_s2.status;
	assign epoch_started   = res_s2.epoch_started;
	assign sketch_complete = res_s2.complete;
	assign fragments_held  = res_s2.held;
	assign read_pair_0     = rp[0];
	assign read_pair_1     = rp[1];
	assign read_pair_2     = rp[2];
	assign read_pair_3     = rp[3];
	assign read_pair_4     = rp[4];

	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without a command two cycles earlier");

	a_epoch_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && epoch_started |-> status == skc_pkg::ST_OK || status == skc_pkg::ST_DUP)
		else $error("epoch start reported on a rejected beat");

	a_complete_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && sketch_complete |-> status == skc_pkg::ST_OK
			&& fragments_held == skc_pkg::HELD_W'(FRAGS))
		else $error("completion without a full set of fragments");

	a_bad_switch_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == skc_pkg::ST_BAD_SWITCH |-> fragments_held == '0
			&& !epoch_started && read_pair_0 == '0)
		else $error("bad switch beat carries data");

	a_read_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != skc_pkg::ST_OK |-> read_pair_0 == '0 && read_pair_4 == '0)
		else $error("read data on a beat that is not a good read");

endmodule

// ===== sv/skc_ram.sv =====
module skc_ram #(
	parameter int WIDTH = 320,
	parameter int DEPTH = 288
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/skc_state.sv =====
module skc_state #(
	parameter int NUM_SWITCHES = 6,
	parameter int NUM_ARRAYS   = 3,
	parameter int NUM_BUCKETS  = 16,
	localparam int FRAGS  = NUM_ARRAYS * NUM_BUCKETS,
	localparam int SLOT_W = NUM_SWITCHES > 1 ? $clog2(NUM_SWITCHES) : 1,
	localparam int FRAG_W = FRAGS > 1 ? $clog2(FRAGS) : 1,
	localparam int CNT_W  = $clog2(FRAGS + 1),
	localparam int DEPTH  = NUM_SWITCHES * FRAGS,
	localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid,
	input  logic                            op,
	input  logic [skc_pkg::SW_W-1:0]        source_switch,
	input  logic [skc_pkg::TAG_W-1:0]       epoch_tag,
	input  logic [skc_pkg::FRAG_IN_W-1:0]   fragment_index,
	input  logic [skc_pkg::SW_W-1:0]        base_switch_id,
	output skc_pkg::res_t                   res,
	output logic [ADDR_W-1:0]               addr
);

	logic                             seen_q [NUM_SWITCHES];
	logic [skc_pkg::TAG_W-1:0]        epoch_q [NUM_SWITCHES];
	logic [CNT_W-1:0]                 cnt_q [NUM_SWITCHES];
	logic [FRAGS-1:0]                 marks_q [NUM_SWITCHES];

	logic [skc_pkg::SW_W:0] diff;
	logic                   sw_bad;
	logic                   fr_bad;
	logic [SLOT_W-1:0]      slot;
	logic [FRAG_W-1:0]      frag;
	logic                   new_ep;
	logic [FRAGS-1:0]       marks;
	logic [CNT_W-1:0]       cnt;
	logic                   hit;
	logic [CNT_W-1:0]       cnt_n;
	logic                   upd;

	assign diff   = {1'b0, source_switch} - {1'b0, base_switch_id};
	assign sw_bad = diff[skc_pkg::SW_W]
		|| (diff[skc_pkg::SW_W-1:0] >= skc_pkg::SW_W'(NUM_SWITCHES));
	assign fr_bad = fragment_index >= skc_pkg::FRAG_IN_W'(FRAGS);
	assign slot   = diff[SLOT_W-1:0];
	assign frag   = fragment_index[FRAG_W-1:0];
	assign addr   = ADDR_W'(slot * FRAGS) + ADDR_W'(frag);

	assign new_ep = !seen_q[slot] || (epoch_q[slot] != epoch_tag);
	assign marks  = new_ep ? '0 : marks_q[slot];
	assign cnt    = new_ep ? '0 : cnt_q[slot];
	assign hit    = marks[frag];
	assign cnt_n  = hit ? cnt : cnt + 1'b1;
	assign upd    = valid && !sw_bad && !fr_bad && (op == skc_pkg::OP_STORE);

	always_comb begin
		res = '0;
		res.status = skc_pkg::ST_OK;
		if (sw_bad) begin
			res.status = skc_pkg::ST_BAD_SWITCH;
		end else if (fr_bad) begin
			res.status = skc_pkg::ST_BAD_FRAG;
			res.held   = skc_pkg::HELD_W'(cnt_q[slot]);
		end else if (op == skc_pkg::OP_READ) begin
			res.status = marks_q[slot][frag] ? skc_pkg::ST_OK : skc_pkg::ST_DUP;
			res.rd_hit = marks_q[slot][frag];
			res.held   = skc_pkg::HELD_W'(cnt_q[slot]);
		end else begin
			res.status        = hit ? skc_pkg::ST_DUP : skc_pkg::ST_OK;
			res.epoch_started = new_ep;
			res.wr            = !hit;
			res.complete      = !hit && (cnt_n == CNT_W'(FRAGS));
			res.held          = skc_pkg::HELD_W'(cnt_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SWITCHES; i++) begin
				seen_q[i]  <= 1'b0;
				epoch_q[i] <= '0;
				cnt_q[i]   <= '0;
				marks_q[i] <= '0;
			end
		end else if (upd) begin
			seen_q[slot]  <= 1'b1;
			epoch_q[slot] <= epoch_tag;
			cnt_q[slot]   <= cnt_n;
			marks_q[slot] <= marks | (FRAGS'(1) << frag);
		end
	end

endmodule
